// ===== rtl/fof_grain_overlap_sum_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grain overlap adder
// Concurrent assertion shorthands; all sample on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef FOF_GRAIN_OVERLAP_SUM_MACROS_SVH
`define FOF_GRAIN_OVERLAP_SUM_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define FOGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also holds across reset.
`define FOGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fogs_pkg.sv =====
// ----------------------------------------------------------------------------
// fogs_pkg
// Shared types and constants of the grain overlap adder.
// ----------------------------------------------------------------------------
package fogs_pkg;

  // Grain table geometry.
  localparam int unsigned TABLE_DEPTH = 2048;
  localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned IDX_W  = 32;
  localparam int unsigned PER_W  = 12;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned OUT_W  = 27;

  // Walk position must hold the bound plus one period.
  localparam int unsigned POS_W  = ((TBL_AW > PER_W) ? TBL_AW : PER_W) + 1;
  // Accumulator holds TABLE_DEPTH full-scale words without overflow.
  localparam int unsigned ACC_W  = VAL_W + TBL_AW + 1;
  // Remainder unit retires one index bit per cycle.
  localparam int unsigned DIV_CW = $clog2(IDX_W);

  // Queue between front and back; depth is a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Grain length after reset.
  localparam logic [LEN_W-1:0] GLEN_RESET = 12'd2048;

  // Saturation limits of the result.
  localparam logic signed [63:0] OUT_MAX = 64'sd67108863;
  localparam logic signed [63:0] OUT_MIN = -64'sd67108864;

  // Item kind, coded as the mode field.
  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } fogs_kind_t;

  // Classified item as it travels through the queue.
  typedef struct packed {
    fogs_kind_t               kind;
    logic                     wr_ok;
    logic [ADDR_W-1:0]        addr;
    logic signed [VAL_W-1:0]  value;
    logic [IDX_W-1:0]         index;
    logic [PER_W-1:0]         period;
  } fogs_item_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_WALK,
    BK_DONE
  } fogs_bk_state_t;

endpackage

// ===== rtl/fogs_front.sv =====
// ----------------------------------------------------------------------------
// fogs_front
// Input side: takes input beats and classifies them for the back end.
// ----------------------------------------------------------------------------
module fogs_front (
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic [fogs_pkg::ADDR_W-1:0]           in_table_address,
  input  logic signed [fogs_pkg::VAL_W-1:0]     in_table_value,
  input  logic [fogs_pkg::IDX_W-1:0]            in_sample_index,
  input  logic [fogs_pkg::PER_W-1:0]            in_pulse_period,
  input  logic                                  q_full,
  output logic                                  q_push,
  output fogs_pkg::fogs_item_t                  q_item
);

  // Stall only when the queue has no room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the beat: kind, whether the write lands in the table, and a
  // period of zero taken as one.
  always_comb begin
    q_item.kind   = fogs_pkg::fogs_kind_t'(in_mode);
    q_item.wr_ok  = (32'(in_table_address) < 32'(fogs_pkg::TABLE_DEPTH));
    q_item.addr   = in_table_address;
    q_item.value  = in_table_value;
    q_item.index  = in_sample_index;
    q_item.period = (in_pulse_period == '0) ? fogs_pkg::PER_W'(1) : in_pulse_period;
  end

endmodule

// ===== rtl/fogs_queue.sv =====
// ----------------------------------------------------------------------------
// fogs_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module fogs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fogs_pkg::fogs_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output fogs_pkg::fogs_item_t pop_item
);

  fogs_pkg::fogs_item_t              entry_r [fogs_pkg::QUEUE_DEPTH];
  logic [fogs_pkg::QUEUE_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [fogs_pkg::QUEUE_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [fogs_pkg::QUEUE_AW:0]       count_r, count_nxt;

  assign full      = (count_r == (fogs_pkg::QUEUE_AW + 1)'(fogs_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];

  // Pointer and fill count update; pointers wrap naturally.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop && pop_valid) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !(pop && pop_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && pop_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/fogs_back.sv =====
// ----------------------------------------------------------------------------
// fogs_back
// Back end: grain table, remainder unit, grain walk and output register.
// ----------------------------------------------------------------------------
module fogs_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  fogs_pkg::fogs_item_t                  q_item,
  output logic                                  q_pop,
  input  logic                                  cfg_wr_en,
  input  logic [fogs_pkg::LEN_W-1:0]            cfg_wr_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fogs_pkg::OUT_W-1:0]     out_sample_value
);

  // Grain table memory, one write and one registered read port.
  logic signed [fogs_pkg::VAL_W-1:0] table_mem [fogs_pkg::TABLE_DEPTH];
  logic signed [fogs_pkg::VAL_W-1:0] rd_data_r;
  logic                              rd_vld_r, rd_vld_nxt;
  logic                              mem_we, mem_re;
  logic [fogs_pkg::TBL_AW-1:0]       mem_waddr, mem_raddr;

  fogs_pkg::fogs_bk_state_t          state_r, state_nxt;
  logic [fogs_pkg::LEN_W-1:0]        glen_r;
  logic [fogs_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [fogs_pkg::PER_W-1:0]        per_r, per_nxt;
  logic [fogs_pkg::PER_W-1:0]        rem_r, rem_nxt;
  logic [fogs_pkg::DIV_CW-1:0]       div_cnt_r, div_cnt_nxt;
  logic [fogs_pkg::TBL_AW-1:0]       bound_r, bound_nxt;
  logic                              empty_r, empty_nxt;
  logic [fogs_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic signed [fogs_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [fogs_pkg::OUT_W-1:0] out_value_r, out_value_nxt;

  logic                              take_sample;
  logic                              div_last;
  logic                              walk_stop;
  logic                              res_fire;
  logic [31:0]                       len_clamp;
  logic [31:0]                       bound_full;
  logic [fogs_pkg::PER_W:0]          rem_shift;
  logic [fogs_pkg::PER_W:0]          rem_sub;
  logic [fogs_pkg::PER_W-1:0]        rem_step;
  logic signed [63:0]                acc_wide;

  assign take_sample = (state_r == fogs_pkg::BK_IDLE) && q_valid
                       && (q_item.kind == fogs_pkg::KIND_SAMPLE);
  assign div_last    = (div_cnt_r == fogs_pkg::DIV_CW'(fogs_pkg::IDX_W - 1));
  assign walk_stop   = empty_r || (pos_r > fogs_pkg::POS_W'(bound_r));
  assign res_fire    = (state_r == fogs_pkg::BK_DONE) && (!out_valid_r || !out_stall);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fogs_pkg::BK_IDLE: begin
        if (take_sample) begin
          state_nxt = fogs_pkg::BK_DIV;
        end
      end
      fogs_pkg::BK_DIV: begin
        if (div_last) begin
          state_nxt = fogs_pkg::BK_WALK;
        end
      end
      fogs_pkg::BK_WALK: begin
        if (walk_stop) begin
          state_nxt = fogs_pkg::BK_DONE;
        end
      end
      fogs_pkg::BK_DONE: begin
        if (res_fire) begin
          state_nxt = fogs_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = fogs_pkg::BK_IDLE;
      end
    endcase
  end

  // Clamp the grain length and bound the walk by the sample index.
  always_comb begin
    len_clamp = (32'(glen_r) > 32'(fogs_pkg::TABLE_DEPTH)) ?
                32'(fogs_pkg::TABLE_DEPTH) : 32'(glen_r);
    bound_full = (q_item.index < (len_clamp - 32'd1)) ? q_item.index
                                                      : (len_clamp - 32'd1);
  end

  // One restoring step of the index modulo period.
  always_comb begin
    rem_shift = {rem_r, idx_r[fogs_pkg::IDX_W-1]};
    rem_sub   = rem_shift - {1'b0, per_r};
    rem_step  = (rem_shift >= {1'b0, per_r}) ? rem_sub[fogs_pkg::PER_W-1:0]
                                             : rem_shift[fogs_pkg::PER_W-1:0];
  end

  // Datapath and control outputs of each state.
  always_comb begin
    q_pop         = (state_r == fogs_pkg::BK_IDLE) && q_valid;
    mem_we        = (state_r == fogs_pkg::BK_IDLE) && q_valid
                    && (q_item.kind == fogs_pkg::KIND_LOAD) && q_item.wr_ok;
    mem_waddr     = fogs_pkg::TBL_AW'(q_item.addr);
    mem_re        = (state_r == fogs_pkg::BK_WALK) && !walk_stop;
    mem_raddr     = pos_r[fogs_pkg::TBL_AW-1:0];
    rd_vld_nxt    = mem_re;
    idx_nxt       = idx_r;
    per_nxt       = per_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    bound_nxt     = bound_r;
    empty_nxt     = empty_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    acc_wide      = 64'(acc_r);
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && out_stall;

    // A returning table word joins the sum.
    if (rd_vld_r) begin
      acc_nxt = acc_r + fogs_pkg::ACC_W'(rd_data_r);
    end

    case (state_r)
      fogs_pkg::BK_IDLE: begin
        if (take_sample) begin
          idx_nxt     = q_item.index;
          per_nxt     = q_item.period;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          bound_nxt   = fogs_pkg::TBL_AW'(bound_full);
          empty_nxt   = (len_clamp == 32'd0);
          acc_nxt     = '0;
        end
      end
      fogs_pkg::BK_DIV: begin
        rem_nxt     = rem_step;
        idx_nxt     = {idx_r[fogs_pkg::IDX_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_last) begin
          pos_nxt = fogs_pkg::POS_W'(rem_step);
        end
      end
      fogs_pkg::BK_WALK: begin
        if (!walk_stop) begin
          pos_nxt = pos_r + fogs_pkg::POS_W'(per_r);
        end
      end
      fogs_pkg::BK_DONE: begin
        // Saturate the sum into the result range.
        if (acc_wide > fogs_pkg::OUT_MAX) begin
          out_value_nxt = fogs_pkg::OUT_W'(fogs_pkg::OUT_MAX);
        end else if (acc_wide < fogs_pkg::OUT_MIN) begin
          out_value_nxt = fogs_pkg::OUT_W'(fogs_pkg::OUT_MIN);
        end else begin
          out_value_nxt = fogs_pkg::OUT_W'(acc_r);
        end
        if (res_fire) begin
          out_valid_nxt = 1'b1;
        end else begin
          out_value_nxt = out_value_r;
        end
      end
      default: begin
        out_value_nxt = out_value_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fogs_pkg::BK_IDLE;
      glen_r      <= fogs_pkg::GLEN_RESET;
      div_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        glen_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    per_r       <= per_nxt;
    rem_r       <= rem_nxt;
    bound_r     <= bound_nxt;
    empty_r     <= empty_nxt;
    pos_r       <= pos_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
  end

  // Grain table write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= q_item.value;
    end
    if (mem_re) begin
      rd_data_r <= table_mem[mem_raddr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule

// ===== rtl/fof_grain_overlap_sum.sv =====
// ----------------------------------------------------------------------------
// fof_grain_overlap_sum
// Formant grain synthesizer core: sums overlapping grain table words.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Beat contents
//  in_      input      in_valid/in_stall    mode, table address/value, index, period
//  out_     output     out_valid/out_stall  sample_value, one per sample beat
//  cfg_     input      cfg_wr_en            grain_length (write only)
//
// A load beat is written to the table as the back end takes it. A sample beat
// passes through the sequencer states in order: the back end takes the beat,
// the remainder unit retires one index bit per cycle, the single table read
// port fetches one grain word per cycle until the walk ends, and the result
// is loaded into the output register once the output is free. The input side takes
// beats into a two-entry queue while the back end works or the output is stalled.
// Reset is synchronous and clears control state only; the table is undefined
// until written and has no clearing pass.
// ----------------------------------------------------------------------------
module fof_grain_overlap_sum (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic [fogs_pkg::ADDR_W-1:0]           in_table_address,
  input  logic signed [fogs_pkg::VAL_W-1:0]     in_table_value,
  input  logic [fogs_pkg::IDX_W-1:0]            in_sample_index,
  input  logic [fogs_pkg::PER_W-1:0]            in_pulse_period,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fogs_pkg::OUT_W-1:0]     out_sample_value,
  input  logic                                  cfg_wr_en,
  input  logic [fogs_pkg::LEN_W-1:0]            cfg_wr_data
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  fogs_pkg::fogs_item_t front_item;
  fogs_pkg::fogs_item_t back_item;

  // Accept and classify input beats.
  fogs_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_sample_index  (in_sample_index),
    .in_pulse_period  (in_pulse_period),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (front_item)
  );

  // Decouple the two sides.
  fogs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (back_item)
  );

  // Table writes, grain walk and result delivery.
  fogs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (back_item),
    .q_pop            (q_pop),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value)
  );

endmodule

// ===== rtl/fogs_checker.sv =====
// ----------------------------------------------------------------------------
// fogs_checker
// Port-level checks of the grain overlap adder, bound to the top level.
// ----------------------------------------------------------------------------
`include "fof_grain_overlap_sum_macros.svh"

module fogs_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  in_mode,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [fogs_pkg::OUT_W-1:0]     out_sample_value
);

  logic [2:0] pend_r, pend_nxt;
  logic       samp_beat;
  logic       out_beat;

  assign samp_beat = in_valid && !in_stall && in_mode;
  assign out_beat  = out_valid && !out_stall;

  // Sample beats accepted whose results are not yet delivered.
  always_comb begin
    pend_nxt = pend_r + 3'(samp_beat) - 3'(out_beat && (pend_r != 3'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `FOGS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `FOGS_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_sample_value), "result moved")
  `FOGS_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result shown after reset")
  `FOGS_ASSERT(a_no_extra, out_beat |-> (pend_r != 3'd0), "result without a sample beat")
  `FOGS_ASSERT(a_pend_cap, pend_r <= 3'd4, "more sample beats in flight than storage")

endmodule

bind fof_grain_overlap_sum fogs_checker u_fogs_checker (.*);
